FILE: rtl/hsvrgb_pkg.sv
// Shared types, constants and helpers for the HSV to RGB converter.
// Used by every module in rtl/; depends on nothing else.

package hsvrgb_pkg;

    // Register stages from input transfer to output register
    parameter int unsigned NUM_STAGES = 5;

    // Rainbow green trim factor (x/256)
    parameter logic [7:0] GREEN_SCALE = 8'd185;

    // Generic mode hue region boundaries (43 hue steps per region)
    parameter logic [7:0] REGION_SPAN = 8'd43;

    typedef enum logic [1:0] {
        MODE_RAINBOW = 2'd0,
        MODE_RAW     = 2'd1,
        MODE_GENERIC = 2'd2
    } alg_mode_t;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] value;
    } hsv_pixel_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_pixel_t;

    // Per-stage load enables plus the mode that rides with the last datapath stage
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        alg_mode_t             mode;
    } hsvrgb_ctl_t;

    // 8x8 product, upper byte
    function automatic logic [7:0] scale8(input logic [7:0] a, input logic [7:0] b);
        logic [15:0] prod;
        prod = {8'd0, a} * {8'd0, b};
        return prod[15:8];
    endfunction

endpackage

FILE: rtl/hsvrgb_ctrl.sv
// Pipeline control for the HSV to RGB converter: valid bits, ready chain, mode tags.
// Depends on hsvrgb_pkg.

module hsvrgb_ctrl
    import hsvrgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  alg_mode_t   cur_mode,
    output hsvrgb_ctl_t ctl
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] ready;
    alg_mode_t             mode_reg [NUM_STAGES-1];

    // A stage may load when it is empty or its contents move on
    always_comb
    begin
        ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    // Valid bits follow the data
    always_comb
    begin
        valid_next[0] = ready[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            valid_next[k] = ready[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Mode tag travels with each pixel through the datapath stages
    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            mode_reg[0] <= cur_mode;
        end
        for (int k = 1; k < NUM_STAGES - 1; k++)
        begin
            if (ready[k])
            begin
                mode_reg[k] <= mode_reg[k-1];
            end
        end
    end

    assign ctl.load  = ready;
    assign ctl.mode  = mode_reg[NUM_STAGES-2];
    assign in_ready  = ready[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

endmodule

FILE: rtl/hsvrgb_rainbow.sv
// Rainbow conversion datapath: hue sections, green trim, saturation, squared value.
// Four register stages; depends on hsvrgb_pkg.

module hsvrgb_rainbow
    import hsvrgb_pkg::*;
(
    input  logic        clk,
    input  hsvrgb_ctl_t ctl,
    input  hsv_pixel_t  hsv,
    output rgb_pixel_t  rgb
);

    // Nonzero channel scaled, plus one; zero stays zero
    function automatic logic [7:0] scale_nz(input logic [7:0] c, input logic [7:0] f);
        return (c == 8'd0) ? 8'd0 : scale8(c, f) + 8'd1;
    endfunction

    // Stage 1: hue section mapping, value squared
    logic [7:0] off8, third, twoth;
    logic [7:0] r1_next, g1_next, b1_next;
    logic [7:0] r1_reg, g1_reg, b1_reg, sat1_reg, val1_reg, vsq1_reg, dinv1_reg;

    always_comb
    begin
        off8  = {hsv.hue[4:0], 3'b000};
        third = scale8(off8, 8'd85);
        twoth = scale8(off8, 8'd170);
        case (hsv.hue[7:5])
            3'd0:
            begin
                r1_next = 8'd255 - third; g1_next = third;            b1_next = 8'd0;
            end
            3'd1:
            begin
                r1_next = 8'd171;         g1_next = 8'd85 + third;    b1_next = 8'd0;
            end
            3'd2:
            begin
                r1_next = 8'd171 - twoth; g1_next = 8'd170 + third;   b1_next = 8'd0;
            end
            3'd3:
            begin
                r1_next = 8'd0;           g1_next = 8'd255 - third;   b1_next = third;
            end
            3'd4:
            begin
                r1_next = 8'd0;           g1_next = 8'd171 - twoth;   b1_next = 8'd85 + twoth;
            end
            3'd5:
            begin
                r1_next = third;          g1_next = 8'd0;             b1_next = 8'd255 - third;
            end
            3'd6:
            begin
                r1_next = 8'd85 + third;  g1_next = 8'd0;             b1_next = 8'd171 - third;
            end
            default:
            begin
                r1_next = 8'd170 + third; g1_next = 8'd0;             b1_next = 8'd85 - third;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            r1_reg    <= r1_next;
            g1_reg    <= g1_next;
            b1_reg    <= b1_next;
            sat1_reg  <= hsv.saturation;
            val1_reg  <= hsv.value;
            vsq1_reg  <= scale8(hsv.value, hsv.value);
            dinv1_reg <= ~hsv.saturation;
        end
    end

    // Stage 2: green trim, squared desaturation floor
    logic [7:0] r2_reg, g2_reg, b2_reg, sat2_reg, val2_reg, vsq2_reg, dd2_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            r2_reg   <= r1_reg;
            g2_reg   <= scale8(g1_reg, GREEN_SCALE);
            b2_reg   <= b1_reg;
            sat2_reg <= sat1_reg;
            val2_reg <= val1_reg;
            vsq2_reg <= vsq1_reg;
            dd2_reg  <= scale8(dinv1_reg, dinv1_reg);
        end
    end

    // Stage 3: saturation, floor added mod 256
    logic [7:0] r3_next, g3_next, b3_next;
    logic [7:0] r3_reg, g3_reg, b3_reg, val3_reg, vsq3_reg;

    always_comb
    begin
        if (sat2_reg == 8'd255)
        begin
            r3_next = r2_reg;
            g3_next = g2_reg;
            b3_next = b2_reg;
        end
        else if (sat2_reg == 8'd0)
        begin
            r3_next = 8'd255;
            g3_next = 8'd255;
            b3_next = 8'd255;
        end
        else
        begin
            r3_next = scale_nz(r2_reg, sat2_reg) + dd2_reg;
            g3_next = scale_nz(g2_reg, sat2_reg) + dd2_reg;
            b3_next = scale_nz(b2_reg, sat2_reg) + dd2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[2])
        begin
            r3_reg   <= r3_next;
            g3_reg   <= g3_next;
            b3_reg   <= b3_next;
            val3_reg <= val2_reg;
            vsq3_reg <= vsq2_reg;
        end
    end

    // Stage 4: squared value; black when it rounds to zero
    rgb_pixel_t rgb4_next, rgb4_reg;

    always_comb
    begin
        if (val3_reg == 8'd255)
        begin
            rgb4_next = '{red: r3_reg, green: g3_reg, blue: b3_reg};
        end
        else if (vsq3_reg == 8'd0)
        begin
            rgb4_next = '0;
        end
        else
        begin
            rgb4_next.red   = scale_nz(r3_reg, vsq3_reg);
            rgb4_next.green = scale_nz(g3_reg, vsq3_reg);
            rgb4_next.blue  = scale_nz(b3_reg, vsq3_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[3])
        begin
            rgb4_reg <= rgb4_next;
        end
    end

    assign rgb = rgb4_reg;

endmodule

FILE: rtl/hsvrgb_raw.sv
// Raw conversion datapath: four 64-step hue ramps above a brightness floor.
// Four register stages; depends on hsvrgb_pkg.

module hsvrgb_raw
    import hsvrgb_pkg::*;
(
    input  logic        clk,
    input  hsvrgb_ctl_t ctl,
    input  hsv_pixel_t  hsv,
    output rgb_pixel_t  rgb
);

    // Stage 1: floor = val * (255 - sat) / 256
    logic [7:0] floor1_reg, val1_reg;
    logic [5:0] off1_reg;
    logic [1:0] sec1_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            floor1_reg <= scale8(hsv.value, ~hsv.saturation);
            val1_reg   <= hsv.value;
            off1_reg   <= hsv.hue[5:0];
            sec1_reg   <= hsv.hue[7:6];
        end
    end

    // Stage 2: ramp amplitude (floor never exceeds value)
    logic [7:0] amp2_reg, floor2_reg;
    logic [5:0] off2_reg;
    logic [1:0] sec2_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            amp2_reg   <= val1_reg - floor1_reg;
            floor2_reg <= floor1_reg;
            off2_reg   <= off1_reg;
            sec2_reg   <= sec1_reg;
        end
    end

    // Stage 3: rising and falling ramps, wrapped to 8 bits
    logic [13:0] up_prod, down_prod;
    logic [7:0]  up3_reg, down3_reg, floor3_reg;
    logic [1:0]  sec3_reg;

    always_comb
    begin
        up_prod   = 14'(off2_reg) * 14'(amp2_reg);
        down_prod = 14'(6'd63 - off2_reg) * 14'(amp2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[2])
        begin
            up3_reg    <= up_prod[13:6] + floor2_reg;
            down3_reg  <= down_prod[13:6] + floor2_reg;
            floor3_reg <= floor2_reg;
            sec3_reg   <= sec2_reg;
        end
    end

    // Stage 4: channel routing by section; upper two sections share one mapping
    rgb_pixel_t rgb4_next, rgb4_reg;

    always_comb
    begin
        case (sec3_reg)
            2'd0:    rgb4_next = '{red: down3_reg,  green: up3_reg,    blue: floor3_reg};
            2'd1:    rgb4_next = '{red: floor3_reg, green: down3_reg,  blue: up3_reg};
            default: rgb4_next = '{red: up3_reg,    green: floor3_reg, blue: down3_reg};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[3])
        begin
            rgb4_reg <= rgb4_next;
        end
    end

    assign rgb = rgb4_reg;

endmodule

FILE: rtl/hsvrgb_generic.sv
// Generic six-region conversion datapath with p/q/t terms.
// Four register stages; depends on hsvrgb_pkg.

module hsvrgb_generic
    import hsvrgb_pkg::*;
(
    input  logic        clk,
    input  hsvrgb_ctl_t ctl,
    input  hsv_pixel_t  hsv,
    output rgb_pixel_t  rgb
);

    // Stage 1: region by compare chain, remainder times six, p term
    logic [2:0] region1_next;
    logic [7:0] base1, diff1;
    logic [7:0] rem1_next;

    always_comb
    begin
        if (hsv.hue < REGION_SPAN)
        begin
            region1_next = 3'd0; base1 = 8'd0;
        end
        else if (hsv.hue < 8'(2 * REGION_SPAN))
        begin
            region1_next = 3'd1; base1 = REGION_SPAN;
        end
        else if (hsv.hue < 8'(3 * REGION_SPAN))
        begin
            region1_next = 3'd2; base1 = 8'(2 * REGION_SPAN);
        end
        else if (hsv.hue < 8'(4 * REGION_SPAN))
        begin
            region1_next = 3'd3; base1 = 8'(3 * REGION_SPAN);
        end
        else if (hsv.hue < 8'(5 * REGION_SPAN))
        begin
            region1_next = 3'd4; base1 = 8'(4 * REGION_SPAN);
        end
        else
        begin
            region1_next = 3'd5; base1 = 8'(5 * REGION_SPAN);
        end
        diff1     = hsv.hue - base1;
        rem1_next = {diff1[5:0], 2'b00} + {1'b0, diff1[5:0], 1'b0};
    end

    logic [2:0] region1_reg;
    logic [7:0] rem1_reg, p1_reg, val1_reg, sat1_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            region1_reg <= region1_next;
            rem1_reg    <= rem1_next;
            p1_reg      <= scale8(hsv.value, ~hsv.saturation);
            val1_reg    <= hsv.value;
            sat1_reg    <= hsv.saturation;
        end
    end

    // Stage 2: saturation times remainder and its complement
    logic [2:0] region2_reg;
    logic [7:0] a2_reg, b2_reg, p2_reg, val2_reg;
    logic       grey2_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            region2_reg <= region1_reg;
            a2_reg      <= scale8(sat1_reg, rem1_reg);
            b2_reg      <= scale8(sat1_reg, ~rem1_reg);
            p2_reg      <= p1_reg;
            val2_reg    <= val1_reg;
            grey2_reg   <= (sat1_reg == 8'd0);
        end
    end

    // Stage 3: q and t terms
    logic [2:0] region3_reg;
    logic [7:0] q3_reg, t3_reg, p3_reg, val3_reg;
    logic       grey3_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load[2])
        begin
            region3_reg <= region2_reg;
            q3_reg      <= scale8(val2_reg, ~a2_reg);
            t3_reg      <= scale8(val2_reg, ~b2_reg);
            p3_reg      <= p2_reg;
            val3_reg    <= val2_reg;
            grey3_reg   <= grey2_reg;
        end
    end

    // Stage 4: region routing, grey when unsaturated
    rgb_pixel_t rgb4_next, rgb4_reg;

    always_comb
    begin
        if (grey3_reg)
        begin
            rgb4_next = '{red: val3_reg, green: val3_reg, blue: val3_reg};
        end
        else
        begin
            case (region3_reg)
                3'd0:    rgb4_next = '{red: val3_reg, green: t3_reg,   blue: p3_reg};
                3'd1:    rgb4_next = '{red: q3_reg,   green: val3_reg, blue: p3_reg};
                3'd2:    rgb4_next = '{red: p3_reg,   green: val3_reg, blue: t3_reg};
                3'd3:    rgb4_next = '{red: p3_reg,   green: q3_reg,   blue: val3_reg};
                3'd4:    rgb4_next = '{red: t3_reg,   green: p3_reg,   blue: val3_reg};
                default: rgb4_next = '{red: val3_reg, green: p3_reg,   blue: q3_reg};
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[3])
        begin
            rgb4_reg <= rgb4_next;
        end
    end

    assign rgb = rgb4_reg;

endmodule

FILE: rtl/hsv_to_rgb_converter.sv
// HSV to RGB converter: one 8-bit HSV pixel in, one 8-bit RGB pixel out per transfer.
// The converter takes a pixel every clock unless a stalled output has filled the pipe. Each
// result is registered in four arithmetic stages, one after another, and then in the
// output register; the output register and the per-stage ready chain let new pixels
// enter while a finished result waits. alg_mode selects rainbow (0), raw ramps (1) or
// generic six-region (2); the unused code 3 converts as generic. The mode is sampled when
// a pixel is accepted, so write it only while the pipe is empty. alg_mode resets to 2.
// Depends on hsvrgb_pkg, hsvrgb_ctrl, hsvrgb_rainbow, hsvrgb_raw, hsvrgb_generic.

module hsv_to_rgb_converter
    import hsvrgb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       hsv_valid,
    output logic       hsv_ready,
    input  hsv_pixel_t hsv,
    output logic       rgb_valid,
    input  logic       rgb_ready,
    output rgb_pixel_t rgb,
    input  logic       alg_mode_valid,
    output logic       alg_mode_ready,
    input  logic [1:0] alg_mode
);

    // Mode register
    alg_mode_t alg_mode_reg;

    assign alg_mode_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alg_mode_reg <= MODE_GENERIC;
        end
        else if (alg_mode_valid)
        begin
            alg_mode_reg <= alg_mode_t'(alg_mode);
        end
    end

    // Pipeline control
    hsvrgb_ctl_t ctl;

    hsvrgb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hsv_valid),
        .in_ready  (hsv_ready),
        .out_valid (rgb_valid),
        .out_ready (rgb_ready),
        .cur_mode  (alg_mode_reg),
        .ctl       (ctl)
    );

    // Datapaths
    rgb_pixel_t rgb_rainbow, rgb_raw, rgb_generic;

    hsvrgb_rainbow u_rainbow (
        .clk (clk),
        .ctl (ctl),
        .hsv (hsv),
        .rgb (rgb_rainbow)
    );

    hsvrgb_raw u_raw (
        .clk (clk),
        .ctl (ctl),
        .hsv (hsv),
        .rgb (rgb_raw)
    );

    hsvrgb_generic u_generic (
        .clk (clk),
        .ctl (ctl),
        .hsv (hsv),
        .rgb (rgb_generic)
    );

    // Output register, picks the datapath named by the pixel's mode tag
    rgb_pixel_t rgb_next, rgb_reg;

    always_comb
    begin
        case (ctl.mode)
            MODE_RAINBOW: rgb_next = rgb_rainbow;
            MODE_RAW:     rgb_next = rgb_raw;
            default:      rgb_next = rgb_generic;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[NUM_STAGES-1])
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign rgb = rgb_reg;

    // An empty output stage means every stage can load, so input is open
    assert property (@(posedge clk) disable iff (!rst_n)
        !rgb_valid |-> hsv_ready)
        else $error("input blocked with empty output stage");

    // With the sink always ready, a pixel reaches the output after the full pipe depth
    assert property (@(posedge clk) disable iff (!rst_n)
        (hsv_valid && hsv_ready && rgb_ready) ##1 rgb_ready ##1 rgb_ready ##1 rgb_ready
            ##1 rgb_ready |=> rgb_valid)
        else $error("accepted pixel did not reach output in time");

    // Input stays open while the sink drains
    assert property (@(posedge clk) disable iff (!rst_n)
        rgb_ready |-> hsv_ready)
        else $error("input blocked while output drains");

endmodule

FILE: tb/hsvrgb_checker.sv
`timescale 1ns / 1ps
// Checker for the HSV to RGB converter: watches the pixel, result and mode channels,
// predicts each RGB result and compares it with what the converter returns.
// Depends on hsvrgb_pkg.

module hsvrgb_checker
    import hsvrgb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       hsv_valid,
    input  logic       hsv_ready,
    input  hsv_pixel_t hsv,
    input  logic       rgb_valid,
    input  logic       rgb_ready,
    input  rgb_pixel_t rgb,
    input  logic       alg_mode_valid,
    input  logic       alg_mode_ready,
    input  logic [1:0] alg_mode,
    output int         fail_count,
    output int         pending_count,
    output int         checked_count
);

    localparam int MAX_REPORTS = 100;

    // One outstanding pixel: what went in, under which mode, and what must come out
    typedef struct packed {
        hsv_pixel_t src;
        logic [1:0] mode;
        rgb_pixel_t rgb;
    } conv_rec_t;

    conv_rec_t  expected_rgb [$];
    logic [1:0] cur_mode;

    // Upper byte of an 8x8 product
    function automatic logic [7:0] mul_hi(input logic [7:0] a, input logic [7:0] b);
        logic [15:0] prod;
        prod = a * b;
        return prod[15:8];
    endfunction

    // Rainbow: eight 32-step hue sections, green trim, saturation then squared value
    function automatic rgb_pixel_t rainbow_rgb(input hsv_pixel_t px);
        logic [7:0] off8, third, twoth, r, g, b, d, v;
        rgb_pixel_t o;
        off8  = {px.hue[4:0], 3'b000};
        third = mul_hi(off8, 8'd85);
        twoth = mul_hi(off8, 8'd170);
        case (px.hue[7:5])
            3'd0:    begin r = 8'd255 - third; g = third;          b = 8'd0;          end
            3'd1:    begin r = 8'd171;         g = 8'd85 + third;  b = 8'd0;          end
            3'd2:    begin r = 8'd171 - twoth; g = 8'd170 + third; b = 8'd0;          end
            3'd3:    begin r = 8'd0;           g = 8'd255 - third; b = third;         end
            3'd4:    begin r = 8'd0;           g = 8'd171 - twoth; b = 8'd85 + twoth; end
            3'd5:    begin r = third;          g = 8'd0;           b = 8'd255 - third; end
            3'd6:    begin r = 8'd85 + third;  g = 8'd0;           b = 8'd171 - third; end
            default: begin r = 8'd170 + third; g = 8'd0;           b = 8'd85 - third; end
        endcase
        g = mul_hi(g, GREEN_SCALE);

        // Saturation: white at zero, else scale and add the squared floor (wraps)
        if (px.saturation != 8'd255) begin
            if (px.saturation == 8'd0) begin
                r = 8'd255;
                g = 8'd255;
                b = 8'd255;
            end
            else begin
                d = 8'd255 - px.saturation;
                if (r != 8'd0) r = mul_hi(r, px.saturation) + 8'd1;
                if (g != 8'd0) g = mul_hi(g, px.saturation) + 8'd1;
                if (b != 8'd0) b = mul_hi(b, px.saturation) + 8'd1;
                d = mul_hi(d, d);
                r = r + d;
                g = g + d;
                b = b + d;
            end
        end

        // Value: squared; black when the square rounds to zero
        if (px.value != 8'd255) begin
            v = mul_hi(px.value, px.value);
            if (v == 8'd0) begin
                r = 8'd0;
                g = 8'd0;
                b = 8'd0;
            end
            else begin
                if (r != 8'd0) r = mul_hi(r, v) + 8'd1;
                if (g != 8'd0) g = mul_hi(g, v) + 8'd1;
                if (b != 8'd0) b = mul_hi(b, v) + 8'd1;
            end
        end
        o.red   = r;
        o.green = g;
        o.blue  = b;
        return o;
    endfunction

    // Raw: four 64-step ramps above a floor set by value and saturation
    function automatic rgb_pixel_t ramp_rgb(input hsv_pixel_t px);
        int unsigned hv, sv, vv, fl, amp, off;
        logic [7:0] up, down, flb;
        rgb_pixel_t o;
        hv   = px.hue;
        sv   = px.saturation;
        vv   = px.value;
        fl   = (vv * (255 - sv)) >> 8;
        amp  = vv - fl;
        off  = hv & 32'h3F;
        up   = 8'((((off * amp) >> 6) + fl) & 32'hFF);
        down = 8'(((((63 - off) * amp) >> 6) + fl) & 32'hFF);
        flb  = 8'(fl);
        case (hv >> 6)
            0:       begin o.red = down; o.green = up;   o.blue = flb;  end
            1:       begin o.red = flb;  o.green = down; o.blue = up;   end
            default: begin o.red = up;   o.green = flb;  o.blue = down; end
        endcase
        return o;
    endfunction

    // Generic: six 43-step regions with p/q/t terms, grey at zero saturation
    function automatic rgb_pixel_t sixzone_rgb(input hsv_pixel_t px);
        int unsigned hv, sv, vv, region, rem, p, q, t;
        logic [7:0] vb, pb, qb, tb;
        rgb_pixel_t o;
        hv = px.hue;
        sv = px.saturation;
        vv = px.value;
        if (sv == 0) begin
            o.red   = px.value;
            o.green = px.value;
            o.blue  = px.value;
            return o;
        end
        region = hv / REGION_SPAN;
        rem    = (hv - region * REGION_SPAN) * 6;
        p      = (vv * (255 - sv)) >> 8;
        q      = (vv * (255 - ((sv * rem) >> 8))) >> 8;
        t      = (vv * (255 - ((sv * (255 - rem)) >> 8))) >> 8;
        vb = px.value;
        pb = 8'(p);
        qb = 8'(q);
        tb = 8'(t);
        case (region)
            0:       begin o.red = vb; o.green = tb; o.blue = pb; end
            1:       begin o.red = qb; o.green = vb; o.blue = pb; end
            2:       begin o.red = pb; o.green = vb; o.blue = tb; end
            3:       begin o.red = pb; o.green = qb; o.blue = vb; end
            4:       begin o.red = tb; o.green = pb; o.blue = vb; end
            default: begin o.red = vb; o.green = pb; o.blue = qb; end
        endcase
        return o;
    endfunction

    // Mode dispatch; the spare code converts as generic
    function automatic rgb_pixel_t convert_hsv(input logic [1:0] mode, input hsv_pixel_t px);
        if (mode == MODE_RAINBOW)
            return rainbow_rgb(px);
        else if (mode == MODE_RAW)
            return ramp_rgb(px);
        else
            return sixzone_rgb(px);
    endfunction

    task automatic report_mismatch(input string what);
        if (fail_count < MAX_REPORTS)
            $display("MISMATCH @%0t: %s", $time, what);
        fail_count++;
    endtask

    // Predict on pixel transfers, compare on result transfers, track mode writes
    always @(posedge clk or negedge rst_n) begin
        conv_rec_t rec;
        if (!rst_n) begin
            cur_mode      = MODE_GENERIC;
            fail_count    = 0;
            checked_count = 0;
            expected_rgb.delete();
            pending_count = 0;
        end
        else begin
            if (hsv_valid && hsv_ready) begin
                rec.src  = hsv;
                rec.mode = cur_mode;
                rec.rgb  = convert_hsv(cur_mode, hsv);
                expected_rgb.push_back(rec);
            end
            if (rgb_valid && rgb_ready) begin
                if (expected_rgb.size() == 0) begin
                    report_mismatch($sformatf("unexpected result rgb=%0d/%0d/%0d",
                                              rgb.red, rgb.green, rgb.blue));
                end
                else begin
                    rec = expected_rgb.pop_front();
                    checked_count++;
                    if (rgb.red !== rec.rgb.red || rgb.green !== rec.rgb.green ||
                        rgb.blue !== rec.rgb.blue)
                        report_mismatch($sformatf(
                            "mode %0d hsv=%0d/%0d/%0d rgb=%0d/%0d/%0d expected %0d/%0d/%0d",
                            rec.mode, rec.src.hue, rec.src.saturation, rec.src.value,
                            rgb.red, rgb.green, rgb.blue,
                            rec.rgb.red, rec.rgb.green, rec.rgb.blue));
                end
            end
            if (alg_mode_valid && alg_mode_ready)
                cur_mode = alg_mode;
            pending_count = expected_rgb.size();
        end
    end

endmodule

FILE: tb/tb_hsv_to_rgb_converter.sv
`timescale 1ns / 1ps
// Testbench top for the HSV to RGB converter: clock, reset, pixel and mode stimulus,
// output back-pressure and the verdict. Depends on hsvrgb_pkg, the converter, hsvrgb_checker.

module tb_hsv_to_rgb_converter;
    import hsvrgb_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned PHASE_PIXELS = 200;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned BURST_PIXELS = 40;
    localparam logic [1:0]  MODE_SPARE   = 2'd3;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       hsv_valid = 1'b0;
    logic       hsv_ready;
    hsv_pixel_t hsv = '0;
    logic       rgb_valid;
    logic       rgb_ready = 1'b0;
    rgb_pixel_t rgb;
    logic       alg_mode_valid = 1'b0;
    logic       alg_mode_ready;
    logic [1:0] alg_mode = 2'd0;

    int fail_count;
    int pending_count;
    int checked_count;

    // Stimulus bookkeeping
    logic [1:0]  cur_mode = MODE_GENERIC;
    int          pixels_per_mode [4];
    int          mode_writes = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_stall_on = 1'b1;
    int unsigned hold_requests = 0;
    int unsigned holds_served = 0;
    int unsigned cycle_count = 0;

    hsv_to_rgb_converter u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .hsv_valid      (hsv_valid),
        .hsv_ready      (hsv_ready),
        .hsv            (hsv),
        .rgb_valid      (rgb_valid),
        .rgb_ready      (rgb_ready),
        .rgb            (rgb),
        .alg_mode_valid (alg_mode_valid),
        .alg_mode_ready (alg_mode_ready),
        .alg_mode       (alg_mode)
    );

    hsvrgb_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .hsv_valid      (hsv_valid),
        .hsv_ready      (hsv_ready),
        .hsv            (hsv),
        .rgb_valid      (rgb_valid),
        .rgb_ready      (rgb_ready),
        .rgb            (rgb),
        .alg_mode_valid (alg_mode_valid),
        .alg_mode_ready (alg_mode_ready),
        .alg_mode       (alg_mode),
        .fail_count     (fail_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count)
    );

    always #5 clk = ~clk;

    // Random byte, leaning toward corners and section boundaries
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 3) != 0)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd1;
            3:       return 8'd254;
            4:       return 8'd15;
            5:       return 8'd16;
            6:       return 8'd43;
            default: return 8'd128;
        endcase
    endfunction

    // One pixel transfer, with an optional random gap in front of it
    task automatic send_pixel(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            hsv_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        hsv_valid <= 1'b1;
        hsv       <= '{hue: h, saturation: s, value: v};
        do @(posedge clk); while (!hsv_ready);
        pixels_per_mode[cur_mode]++;
        @(negedge clk);
    endtask

    // Mode write once the pipe has drained
    task automatic select_mode(input logic [1:0] m);
        hsv_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        alg_mode_valid <= 1'b1;
        alg_mode       <= m;
        do @(posedge clk); while (!alg_mode_ready);
        @(negedge clk);
        alg_mode_valid <= 1'b0;
        cur_mode = m;
        mode_writes++;
    endtask

    // Output side: random stalls, plus long hold-offs on request
    initial begin : rx_side
        @(negedge clk);
        forever begin
            if (hold_requests != holds_served) begin
                holds_served++;
                rgb_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (rx_stall_on && $urandom_range(0, 2) == 0) begin
                rgb_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            else begin
                rgb_ready <= 1'b1;
                repeat (rx_stall_on ? $urandom_range(1, 20) : 1) @(negedge clk);
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding", LIMIT_CYCLES,
                 pending_count);
        $display("CHECKS FAILED");
        $finish;
    end

    // Main stimulus
    initial begin : stimulus
        logic [1:0] phase_modes [7];
        phase_modes[0] = MODE_RAINBOW;
        phase_modes[1] = MODE_RAW;
        phase_modes[2] = MODE_GENERIC;
        phase_modes[3] = MODE_SPARE;
        phase_modes[4] = MODE_GENERIC;
        phase_modes[5] = MODE_RAINBOW;
        phase_modes[6] = MODE_RAW;
        foreach (pixels_per_mode[i]) pixels_per_mode[i] = 0;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: generic at reset value, grey, region borders, full scale
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd200, 8'd0,   8'd255);
        send_pixel(8'd42,  8'd255, 8'd255);
        send_pixel(8'd43,  8'd255, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd200);
        send_pixel(8'd85,  8'd1,   8'd77);

        // Directed: rainbow sections, white at zero saturation, near-white floor,
        // black when the squared value rounds to zero
        select_mode(MODE_RAINBOW);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd31,  8'd255, 8'd255);
        send_pixel(8'd96,  8'd0,   8'd128);
        send_pixel(8'd160, 8'd1,   8'd255);
        send_pixel(8'd224, 8'd254, 8'd255);
        send_pixel(8'd255, 8'd128, 8'd15);
        send_pixel(8'd64,  8'd200, 8'd16);
        send_pixel(8'd128, 8'd255, 8'd0);
        send_pixel(8'd190, 8'd77,  8'd254);

        // Directed: raw ramps, including the shared upper sections
        select_mode(MODE_RAW);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd63,  8'd0,   8'd255);
        send_pixel(8'd64,  8'd128, 8'd128);
        send_pixel(8'd128, 8'd255, 8'd200);
        send_pixel(8'd191, 8'd77,  8'd1);
        send_pixel(8'd255, 8'd255, 8'd0);

        // Directed: spare mode code behaves as generic
        select_mode(MODE_SPARE);
        send_pixel(8'd100, 8'd100, 8'd100);
        send_pixel(8'd255, 8'd0,   8'd255);

        // Random phases over every mode; the last one runs without idling
        foreach (phase_modes[ph]) begin
            select_mode(phase_modes[ph]);
            if (ph == 6) begin
                tx_idle_on  = 1'b0;
                rx_stall_on = 1'b0;
            end
            if (ph == 2) begin
                // Long output hold-off while pixels keep coming back to back
                hold_requests++;
                while (holds_served != hold_requests) @(negedge clk);
                tx_idle_on = 1'b0;
                repeat (BURST_PIXELS) send_pixel(pick_byte(), pick_byte(), pick_byte());
                tx_idle_on = 1'b1;
            end
            repeat (PHASE_PIXELS) send_pixel(pick_byte(), pick_byte(), pick_byte());
        end

        // Drain
        hsv_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (NUM_STAGES + 4) @(negedge clk);

        $display("Converted %0d pixels: rainbow %0d, raw %0d, generic %0d, spare code %0d;",
                 pixels_per_mode[0] + pixels_per_mode[1] + pixels_per_mode[2] +
                 pixels_per_mode[3], pixels_per_mode[0], pixels_per_mode[1],
                 pixels_per_mode[2], pixels_per_mode[3]);
        $display("%0d results checked, %0d mode writes, random stalls and one long output hold.",
                 checked_count, mode_writes);
        if (fail_count == 0 && pending_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
